FILE: src/rct_pkg.sv
`timescale 1ns / 1ps

package rct_pkg;

	// Field widths
	localparam int TIME_W   = 17;
	localparam int TEMP_W   = 10;
	localparam int PERIOD_W = TIME_W + 1;
	localparam int CNT_W    = $clog2(TIME_W);
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Sensor fault reading, -127 C in quarter degrees
	localparam logic signed [TEMP_W-1:0] FAULT_CODE = -10'sd508;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_SENSOR = 3'd1,
		REG_LOW    = 3'd2,
		REG_HIGH   = 3'd3,
		REG_START  = 3'd4,
		REG_STOP   = 3'd5,
		REG_ON     = 3'd6,
		REG_OFF    = 3'd7
	} reg_idx_t;

	// Channel modes
	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_WINDOW = 3'd1;
	localparam logic [2:0] MODE_HEAT   = 3'd2;
	localparam logic [2:0] MODE_COOL   = 3'd3;
	localparam logic [2:0] MODE_CYCLE  = 3'd4;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} st_t;

	// Serial comparator result
	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_t;

endpackage

FILE: src/relay_channel_time_thermo_controller.sv
`timescale 1ns / 1ps

// Relay channel controller: one relay driven by a daily time window, a heater
// or cooler thermostat with hysteresis, or a periodic on/off cycle.
// Input channel (in_valid/in_ready): one tick request carrying time_of_day
// and temperature. Output channel (out_valid/out_ready): drive and
// drive_written for that tick, one result per request.
// APB port: eight word registers at 4*index, to be written only while the block is
// idle; the block itself does not enforce this rule on the writer.
// In the run state the comparators and the remainder unit advance one bit a cycle
// over the 17-bit time field; then the decision state registers the result.
// A new request is taken only once the previous result is registered; in_ready
// returns together with out_valid.
// The output register lets a new request in while a result still waits; if the
// receiver stalls, the next decision holds in its last cycle until the output
// register frees up.
// Reset clears the configuration, state and relay level (off); no result is pending.
module relay_channel_time_thermo_controller
	import rct_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// tick requests
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TIME_W-1:0]        time_of_day,
	input  logic signed [TEMP_W-1:0] temperature,
	// results
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     drive,
	output logic                     drive_written,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	// Configuration registers
	logic [2:0]               mode_q;
	logic                     sensor_q;
	logic [TEMP_W-1:0]        low_q;
	logic [TEMP_W-1:0]        high_q;
	logic [TIME_W-1:0]        start_q;
	logic [TIME_W-1:0]        stop_q;
	logic [TIME_W-1:0]        on_q;
	logic [TIME_W-1:0]        off_q;
	reg_idx_t                 widx;
	logic                     wr_en;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			sensor_q <= 1'b0;
			low_q    <= '0;
			high_q   <= '0;
			start_q  <= '0;
			stop_q   <= '0;
			on_q     <= '0;
			off_q    <= '0;
		end else if (wr_en) begin
			unique case (widx)
				REG_MODE:   mode_q   <= pwdata[2:0];
				REG_SENSOR: sensor_q <= pwdata[0];
				REG_LOW:    low_q    <= pwdata[TEMP_W-1:0];
				REG_HIGH:   high_q   <= pwdata[TEMP_W-1:0];
				REG_START:  start_q  <= pwdata[TIME_W-1:0];
				REG_STOP:   stop_q   <= pwdata[TIME_W-1:0];
				REG_ON:     on_q     <= pwdata[TIME_W-1:0];
				REG_OFF:    off_q    <= pwdata[TIME_W-1:0];
				default:    ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (widx)
			REG_MODE:   prdata[2:0]        = mode_q;
			REG_SENSOR: prdata[0]          = sensor_q;
			REG_LOW:    prdata[TEMP_W-1:0] = low_q;
			REG_HIGH:   prdata[TEMP_W-1:0] = high_q;
			REG_START:  prdata[TIME_W-1:0] = start_q;
			REG_STOP:   prdata[TIME_W-1:0] = stop_q;
			REG_ON:     prdata[TIME_W-1:0] = on_q;
			REG_OFF:    prdata[TIME_W-1:0] = off_q;
			default:    prdata             = '0;
		endcase
	end

	// Sequencer
	st_t              st_q;
	st_t              st_d;
	logic [CNT_W-1:0] cnt_q;
	logic             take;
	logic             run_en;
	logic             last_bit;
	logic             commit;

	assign take     = in_valid & in_ready;
	assign last_bit = (cnt_q == CNT_W'(TIME_W - 1));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_RUN;
			ST_RUN:  if (last_bit) st_d = ST_DONE;
			ST_DONE: if (!out_valid || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		run_en   = 1'b0;
		commit   = 1'b0;
		unique case (st_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  run_en   = 1'b1;
			ST_DONE: commit   = ~out_valid | out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (take) begin
				cnt_q <= '0;
			end else if (run_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand shift registers, LSB out first; temperatures sign-extended
	logic [TIME_W-1:0] t_sh_q;
	logic [TIME_W-1:0] start_sh_q;
	logic [TIME_W-1:0] stop_sh_q;
	logic [TIME_W-1:0] temp_sh_q;
	logic [TIME_W-1:0] low_sh_q;
	logic [TIME_W-1:0] high_sh_q;
	logic              fault_q;

	always_ff @(posedge clk) begin
		if (take) begin
			t_sh_q     <= time_of_day;
			start_sh_q <= start_q;
			stop_sh_q  <= stop_q;
			temp_sh_q  <= TIME_W'(temperature);
			low_sh_q   <= TIME_W'(signed'(low_q));
			high_sh_q  <= TIME_W'(signed'(high_q));
			fault_q    <= (temperature == FAULT_CODE);
		end else if (run_en) begin
			t_sh_q     <= t_sh_q >> 1;
			start_sh_q <= start_sh_q >> 1;
			stop_sh_q  <= stop_sh_q >> 1;
			temp_sh_q  <= temp_sh_q >> 1;
			low_sh_q   <= low_sh_q >> 1;
			high_sh_q  <= high_sh_q >> 1;
		end
	end

	// Serial comparators; on the temperature pairs, sign bits flipped on the last bit for signed order
	cmp_t c_ss;
	cmp_t c_st;
	cmp_t c_tp;
	cmp_t c_lo;
	cmp_t c_hi;
	logic sgn;

	assign sgn = last_bit;

	rct_scmp u_cmp_ss (
		.clk(clk), .arst_n(arst_n), .clr(take), .en(run_en),
		.a(start_sh_q[0]), .b(stop_sh_q[0]), .res(c_ss)
	);

	rct_scmp u_cmp_st (
		.clk(clk), .arst_n(arst_n), .clr(take), .en(run_en),
		.a(start_sh_q[0]), .b(t_sh_q[0]), .res(c_st)
	);

	rct_scmp u_cmp_tp (
		.clk(clk), .arst_n(arst_n), .clr(take), .en(run_en),
		.a(t_sh_q[0]), .b(stop_sh_q[0]), .res(c_tp)
	);

	rct_scmp u_cmp_lo (
		.clk(clk), .arst_n(arst_n), .clr(take), .en(run_en),
		.a(temp_sh_q[0] ^ sgn), .b(low_sh_q[0] ^ sgn), .res(c_lo)
	);

	rct_scmp u_cmp_hi (
		.clk(clk), .arst_n(arst_n), .clr(take), .en(run_en),
		.a(temp_sh_q[0] ^ sgn), .b(high_sh_q[0] ^ sgn), .res(c_hi)
	);

	// Periodic phase: time mod (on + off)
	logic [PERIOD_W-1:0] rem;
	logic [PERIOD_W-1:0] period;

	assign period = {1'b0, on_q} + {1'b0, off_q};

	rct_mod u_mod (
		.clk(clk),
		.load(take),
		.step(run_en),
		.dividend(time_of_day),
		.divisor(period),
		.rem(rem)
	);

	// Rule decision
	logic drive_q;
	logic written_q;
	logic out_valid_q;
	logic lvl;
	logic wr;
	logic heat;

	always_comb begin
		lvl  = drive_q;
		wr   = 1'b0;
		heat = (mode_q == MODE_HEAT);
		unique case (mode_q)
			MODE_WINDOW: begin
				if (start_q != '0 && stop_q != '0) begin
					wr = 1'b1;
					if (c_ss.lt) begin
						lvl = c_st.lt & c_tp.lt;
					end else if (c_ss.gt) begin
						lvl = ~(c_tp.gt & c_st.gt);
					end else begin
						lvl = 1'b0;
					end
				end
			end
			MODE_HEAT, MODE_COOL: begin
				if (sensor_q) begin
					priority if (fault_q) begin
						lvl = 1'b0;
						wr  = 1'b1;
					end else if (c_lo.lt) begin
						lvl = heat;
						wr  = 1'b1;
					end else if (c_hi.gt) begin
						lvl = ~heat;
						wr  = 1'b1;
					end else begin
						wr  = 1'b0;
					end
				end
			end
			MODE_CYCLE: begin
				if (on_q != '0 && off_q != '0) begin
					wr  = 1'b1;
					lvl = ~(rem > {1'b0, on_q});
				end
			end
			default: ;
		endcase
	end

	// Relay level and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (commit) begin
			drive_q     <= lvl;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			written_q <= wr;
		end
	end

	assign out_valid     = out_valid_q;
	assign drive         = drive_q;
	assign drive_written = written_q;

endmodule

FILE: src/rct_scmp.sv
`timescale 1ns / 1ps

// Bit-serial magnitude comparator, LSB first: a later (more significant)
// bit overrides whatever the lower bits decided.
module rct_scmp
	import rct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic en,
	input  logic a,
	input  logic b,
	output cmp_t res
);

	logic lt_q;
	logic gt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (clr) begin
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (en) begin
			lt_q <= (~a & b) | (~(a ^ b) & lt_q);
			gt_q <= (a & ~b) | (~(a ^ b) & gt_q);
		end
	end

	assign res.lt = lt_q;
	assign res.gt = gt_q;

endmodule

FILE: src/rct_mod.sv
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per step, MSB first.
module rct_mod
	import rct_pkg::*;
(
	input  logic                clk,
	input  logic                load,
	input  logic                step,
	input  logic [TIME_W-1:0]   dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic [PERIOD_W-1:0] rem
);

	logic [TIME_W-1:0]   dv_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;

	// shift in next bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dv_q[TIME_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dv_q  <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dv_q <= {dv_q[TIME_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[PERIOD_W-1:0];
			end else begin
				rem_q <= trial[PERIOD_W-1:0];
			end
		end
	end

	assign rem = rem_q;

endmodule

FILE: src/rct_chk.sv
`timescale 1ns / 1ps

module rct_chk
	import rct_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic drive,
	input logic drive_written
);

	// last relay level handed out
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_q <= drive;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(drive_written))
		else $error("result changed while stalled");

	// one tick at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a held level matches the previous one
	a_hold_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !drive_written |-> drive == last_q)
		else $error("held level differs from previous");

	// out_valid does not rise straight after a request taken with no result pending
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

endmodule

bind relay_channel_time_thermo_controller rct_chk u_rct_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.drive(drive),
	.drive_written(drive_written)
);
